// ===== src/mkv_pkg.sv =====
`timescale 1ns / 1ps

package mkv_pkg;

  localparam int ENTRY_W   = 16;
  localparam int POP_W     = 32;
  localparam int STEP_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 15;
  localparam int PROD_W    = 2 * ENTRY_W;
  localparam int WPROD_W   = POP_W + ENTRY_W;

  localparam logic [ENTRY_W-1:0] ONE_Q15  = 16'd32768;
  localparam logic [ENTRY_W-1:0] ZERO_Q15 = 16'd0;
  localparam logic [ENTRY_W-1:0] HALF_Q15 = 16'd16384;

  localparam logic [CFG_IDX_W-1:0] REG_T_FIRST_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T_FIRST_SECOND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T_SECOND_FIRST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_T_SECOND_SECOND = 2'd3;

  localparam logic [ENTRY_W-1:0] RST_T_FIRST_FIRST   = 16'd29491;
  localparam logic [ENTRY_W-1:0] RST_T_FIRST_SECOND  = 16'd3277;
  localparam logic [ENTRY_W-1:0] RST_T_SECOND_FIRST  = 16'd6554;
  localparam logic [ENTRY_W-1:0] RST_T_SECOND_SECOND = 16'd26214;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

  typedef struct packed {
    logic mul_en;
  } pop_ctl_t;

endpackage

// ===== src/mkv_in_if.sv =====
`timescale 1ns / 1ps

interface mkv_in_if;
  import mkv_pkg::*;

  logic               valid;
  logic               ready;
  logic [POP_W-1:0]   pop_first;
  logic [POP_W-1:0]   pop_second;
  logic [STEP_W-1:0]  steps;

  modport source (output valid, output pop_first, output pop_second, output steps,
                  input ready);
  modport sink (input valid, input pop_first, input pop_second, input steps,
                output ready);
endinterface

// ===== src/mkv_out_if.sv =====
`timescale 1ns / 1ps

interface mkv_out_if;
  import mkv_pkg::*;

  logic             valid;
  logic             ready;
  logic [POP_W-1:0] out_first;
  logic [POP_W-1:0] out_second;

  modport source (output valid, output out_first, output out_second, input ready);
  modport sink (input valid, input out_first, input out_second, output ready);
endinterface

// ===== src/mkv_entry_lane.sv =====
`timescale 1ns / 1ps

module mkv_entry_lane
  import mkv_pkg::*;
(
  input  logic               clk,
  input  lane_ctl_t          ctl,
  input  logic [ENTRY_W-1:0] init,
  input  logic [ENTRY_W-1:0] row0,
  input  logic [ENTRY_W-1:0] row1,
  input  logic [ENTRY_W-1:0] col0,
  input  logic [ENTRY_W-1:0] col1,
  output logic [ENTRY_W-1:0] entry
);

  logic [PROD_W-1:0]         prod0;
  logic [PROD_W-1:0]         prod1;
  logic [PROD_W:0]           acc;
  logic [PROD_W-FRAC_W:0]    rnd;
  logic [ENTRY_W-1:0]        entry_next;

  assign prod0 = row0 * col0;
  assign prod1 = row1 * col1;
  assign acc   = {1'b0, prod0} + {1'b0, prod1} + (PROD_W+1)'(HALF_Q15);
  assign rnd   = acc[PROD_W:FRAC_W];

  always_comb begin
    if (rnd[PROD_W-FRAC_W:ENTRY_W] != '0) begin
      entry_next = '1;
    end else begin
      entry_next = rnd[ENTRY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= init;
    end else if (ctl.step) begin
      entry <= entry_next;
    end
  end

endmodule

// ===== src/mkv_pop_lane.sv =====
`timescale 1ns / 1ps

module mkv_pop_lane
  import mkv_pkg::*;
(
  input  logic               clk,
  input  pop_ctl_t           ctl,
  input  logic [POP_W-1:0]   p0,
  input  logic [POP_W-1:0]   p1,
  input  logic [ENTRY_W-1:0] w0,
  input  logic [ENTRY_W-1:0] w1,
  output logic [POP_W-1:0]   value
);

  logic [WPROD_W-1:0]         prod0;
  logic [WPROD_W-1:0]         prod1;
  logic [WPROD_W:0]           acc;
  logic [WPROD_W-FRAC_W:0]    rnd;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod0 <= p0 * w0;
      prod1 <= p1 * w1;
    end
  end

  assign acc = {1'b0, prod0} + {1'b0, prod1} + (WPROD_W+1)'(HALF_Q15);
  assign rnd = acc[WPROD_W:FRAC_W];

  always_comb begin
    if (rnd[WPROD_W-FRAC_W:POP_W] != '0) begin
      value = '1;
    end else begin
      value = rnd[POP_W-1:0];
    end
  end

endmodule

// ===== src/markov_chain_state_after_n_steps.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                  Handshake
// pop       in   pop_first[32], pop_second[32], steps[8]  valid/ready
// res       out  out_first[32], out_second[32]            valid/ready
// cfg       in   cfg_idx[2], cfg_data[16]                 cfg_we, no wait
//
// After accept, the four entry lanes form one matrix product per cycle, once per
// step; the vector products are then registered, and sum, round and saturate feed
// the output register, waiting until it is free; input is then ready again.
// Reset is synchronous; it restores the transition matrix and empties the result.
// A result beat waits in the output register; the next item is accepted meanwhile
// and holds at its sum until the register frees.

module markov_chain_state_after_n_steps
  import mkv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  mkv_in_if.sink               pop,
  mkv_out_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [ENTRY_W-1:0]   cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POW  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [STEP_W-1:0]  count;
  logic [POP_W-1:0]   p0;
  logic [POP_W-1:0]   p1;
  logic [ENTRY_W-1:0] tm [2][2];
  logic [ENTRY_W-1:0] pw [2][2];
  logic [POP_W-1:0]   val [2];
  logic               out_valid;
  logic [POP_W-1:0]   out_first;
  logic [POP_W-1:0]   out_second;
  logic               take;
  logic               emit;
  lane_ctl_t          lane_ctl;
  pop_ctl_t           pop_ctl;

  assign pop.ready  = (state == S_IDLE);
  assign take       = pop.valid && pop.ready;
  assign emit       = (state == S_SUM) && (!out_valid || res.ready);

  assign lane_ctl.load = take;
  assign lane_ctl.step = (state == S_POW);
  assign pop_ctl.mul_en = (state == S_MUL);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          state_next = (pop.steps == '0) ? S_MUL : S_POW;
        end
      end
      S_POW: begin
        if (count == STEP_W'(1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_SUM;
      S_SUM: begin
        if (emit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      count <= pop.steps;
      p0    <= pop.pop_first;
      p1    <= pop.pop_second;
    end else if (state == S_POW) begin
      count <= count - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tm[0][0] <= RST_T_FIRST_FIRST;
      tm[0][1] <= RST_T_FIRST_SECOND;
      tm[1][0] <= RST_T_SECOND_FIRST;
      tm[1][1] <= RST_T_SECOND_SECOND;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_T_FIRST_FIRST:   tm[0][0] <= cfg_data;
        REG_T_FIRST_SECOND:  tm[0][1] <= cfg_data;
        REG_T_SECOND_FIRST:  tm[1][0] <= cfg_data;
        REG_T_SECOND_SECOND: tm[1][1] <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar r = 0; r < 2; r++) begin : g_row
    for (genvar c = 0; c < 2; c++) begin : g_col
      mkv_entry_lane u_lane (
        .clk   (clk),
        .ctl   (lane_ctl),
        .init  ((r == c) ? ONE_Q15 : ZERO_Q15),
        .row0  (pw[r][0]),
        .row1  (pw[r][1]),
        .col0  (tm[0][c]),
        .col1  (tm[1][c]),
        .entry (pw[r][c])
      );
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_pop
    mkv_pop_lane u_pop (
      .clk   (clk),
      .ctl   (pop_ctl),
      .p0    (p0),
      .p1    (p1),
      .w0    (pw[0][c]),
      .w1    (pw[1][c]),
      .value (val[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_first  <= val[0];
      out_second <= val[1];
    end
  end

  assign res.valid      = out_valid;
  assign res.out_first  = out_first;
  assign res.out_second = out_second;

endmodule

// ===== dv/tb_markov_chain_state_after_n_steps.sv =====
`timescale 1ns / 1ps

module tb_markov_chain_state_after_n_steps;
  import mkv_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [POP_W-1:0] POP_FULL = '1;
  localparam logic [ENTRY_W-1:0] ENTRY_FULL = '1;

  class pop_scoreboard;
    typedef struct {
      logic [POP_W-1:0] first;
      logic [POP_W-1:0] second;
    } pop_pair_t;

    logic [ENTRY_W-1:0] trans [2][2];
    pop_pair_t expected_pops[$];
    int errors;

    function new();
      trans[0][0] = RST_T_FIRST_FIRST;
      trans[0][1] = RST_T_FIRST_SECOND;
      trans[1][0] = RST_T_SECOND_FIRST;
      trans[1][1] = RST_T_SECOND_SECOND;
      errors = 0;
    endfunction

    function void set_weight(logic [CFG_IDX_W-1:0] idx, logic [ENTRY_W-1:0] val);
      case (idx)
        REG_T_FIRST_FIRST:   trans[0][0] = val;
        REG_T_FIRST_SECOND:  trans[0][1] = val;
        REG_T_SECOND_FIRST:  trans[1][0] = val;
        REG_T_SECOND_SECOND: trans[1][1] = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] round_q15(logic [63:0] acc);
      return (acc + 64'(HALF_Q15)) >> FRAC_W;
    endfunction

    function pop_pair_t population_after(logic [POP_W-1:0] p0, logic [POP_W-1:0] p1,
                                         logic [STEP_W-1:0] n);
      logic [ENTRY_W-1:0] pw [2][2];
      logic [ENTRY_W-1:0] nxt [2][2];
      logic [63:0] acc;
      logic [63:0] v;
      logic [POP_W-1:0] outs [2];
      pop_pair_t res;
      pw[0][0] = ONE_Q15;
      pw[0][1] = ZERO_Q15;
      pw[1][0] = ZERO_Q15;
      pw[1][1] = ONE_Q15;
      for (int i = 0; i < int'(n); i++) begin
        for (int row = 0; row < 2; row++) begin
          for (int col = 0; col < 2; col++) begin
            acc = 64'(pw[row][0]) * 64'(trans[0][col]) + 64'(pw[row][1]) * 64'(trans[1][col]);
            v = round_q15(acc);
            nxt[row][col] = (v > 64'(ENTRY_FULL)) ? ENTRY_FULL : v[ENTRY_W-1:0];
          end
        end
        pw = nxt;
      end
      for (int col = 0; col < 2; col++) begin
        acc = 64'(p0) * 64'(pw[0][col]) + 64'(p1) * 64'(pw[1][col]);
        v = round_q15(acc);
        outs[col] = (v > 64'(POP_FULL)) ? POP_FULL : v[POP_W-1:0];
      end
      res.first = outs[0];
      res.second = outs[1];
      return res;
    endfunction

    function void note_input(logic [POP_W-1:0] p0, logic [POP_W-1:0] p1,
                             logic [STEP_W-1:0] n);
      expected_pops.push_back(population_after(p0, p1, n));
    endfunction

    function int pending();
      return expected_pops.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [POP_W-1:0] got_first, logic [POP_W-1:0] got_second);
      pop_pair_t want;
      if (expected_pops.size() == 0) begin
        report($sformatf("result %0d/%0d with nothing pending", got_first, got_second));
        return;
      end
      want = expected_pops.pop_front();
      if (got_first !== want.first)
        report($sformatf("out_first got %0d expected %0d", got_first, want.first));
      if (got_second !== want.second)
        report($sformatf("out_second got %0d expected %0d", got_second, want.second));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [ENTRY_W-1:0] cfg_data;
  bit steady;
  int ready_hold = 0;
  int cycles = 0;
  pop_scoreboard sb;

  mkv_in_if pop_ch ();
  mkv_out_if res_ch ();

  markov_chain_state_after_n_steps i_dut (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pop_ch.valid && pop_ch.ready)
        sb.note_input(pop_ch.pop_first, pop_ch.pop_second, pop_ch.steps);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.out_first, res_ch.out_second);
    end
  end

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // hold ready low for a random stretch
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      res_ch.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      ready_hold = idle_len() - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  function automatic logic [POP_W-1:0] rand_pop();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return POP_FULL;
    if (pick == 2) return POP_W'($urandom_range(0, 65535));
    return $urandom;
  endfunction

  task automatic send_pop(input logic [POP_W-1:0] p0, input logic [POP_W-1:0] p1,
                          input logic [STEP_W-1:0] n);
    int gap;
    gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? idle_len() : 0);
    if (gap > 0) begin
      @(negedge clk);
      pop_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pop_ch.valid <= 1'b1;
    pop_ch.pop_first <= p0;
    pop_ch.pop_second <= p1;
    pop_ch.steps <= n;
    do @(posedge clk); while (!pop_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    pop_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ENTRY_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    sb.set_weight(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_matrix(input logic [ENTRY_W-1:0] ff, input logic [ENTRY_W-1:0] fs,
                             input logic [ENTRY_W-1:0] sf, input logic [ENTRY_W-1:0] ss);
    set_reg(REG_T_FIRST_FIRST, ff);
    set_reg(REG_T_FIRST_SECOND, fs);
    set_reg(REG_T_SECOND_FIRST, sf);
    set_reg(REG_T_SECOND_SECOND, ss);
  endtask

  initial begin
    int a;
    int c;
    int pick;
    logic [STEP_W-1:0] n;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    pop_ch.valid = 1'b0;
    pop_ch.pop_first = '0;
    pop_ch.pop_second = '0;
    pop_ch.steps = '0;
    res_ch.ready = 1'b0;
    steady = 1'b0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset matrix
    send_pop('0, '0, 8'd0);
    send_pop(POP_FULL, POP_FULL, 8'd0);
    send_pop(32'h0001_0000, '0, 8'd1);
    send_pop('0, 32'h0001_0000, 8'd1);
    send_pop(POP_FULL, POP_FULL, 8'd1);
    send_pop(32'h1234_5678, 32'h9abc_def0, 8'd3);
    send_pop($urandom, $urandom, 8'd255);
    drain();

    // saturate entries and populations
    load_matrix(ENTRY_FULL, ENTRY_FULL, ENTRY_FULL, ENTRY_FULL);
    send_pop(POP_FULL, POP_FULL, 8'd1);
    send_pop(32'd1, '0, 8'd2);
    send_pop(32'h0001_0000, '0, 8'd255);
    drain();

    load_matrix('0, '0, '0, '0);
    send_pop(POP_FULL, POP_FULL, 8'd5);
    send_pop(POP_FULL, '0, 8'd0);
    drain();

    // half-way values round upward
    load_matrix(16'd128, '0, '0, 16'd128);
    send_pop(32'd128, 32'd384, 8'd1);
    send_pop(32'd128, '0, 8'd2);
    send_pop(32'd3, 32'd5, 8'd1);
    drain();

    load_matrix(ONE_Q15, '0, '0, ONE_Q15);
    send_pop(POP_FULL, POP_FULL, 8'd255);
    send_pop(32'h8000_0001, 32'h7fff_fffe, 8'd17);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      if (ph % 2 == 0) begin
        a = $urandom_range(0, 32768);
        c = $urandom_range(0, 32768);
        load_matrix(ENTRY_W'(a), ENTRY_W'(32768 - a), ENTRY_W'(c), ENTRY_W'(32768 - c));
      end else begin
        load_matrix(ENTRY_W'($urandom_range(0, 65535)), ENTRY_W'($urandom_range(0, 65535)),
                    ENTRY_W'($urandom_range(0, 65535)), ENTRY_W'($urandom_range(0, 65535)));
      end
      for (int k = 0; k < 50; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) n = STEP_W'($urandom_range(0, 4));
        else if (pick < 80) n = STEP_W'($urandom_range(5, 40));
        else if (pick < 95) n = STEP_W'($urandom_range(41, 254));
        else n = 8'd255;
        send_pop(rand_pop(), rand_pop(), n);
      end
      drain();
    end

    steady = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (270) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== markov_chain_state_after_n_steps.f =====
src/mkv_pkg.sv
src/mkv_in_if.sv
src/mkv_out_if.sv
src/mkv_entry_lane.sv
src/mkv_pop_lane.sv
src/markov_chain_state_after_n_steps.sv
dv/tb_markov_chain_state_after_n_steps.sv
